>>> hw/rtl/i2c_master_bit_engine_assert.svh
// Assertion macros for the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define I2CM_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("i2cm: forbidden condition seen");
`define I2CM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm: implication violated");
`else
`define I2CM_ASSERT_NEVER(lbl, clk, rst, cond)
`define I2CM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

  localparam int DELAY_W = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd90;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_STOP  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       ack_to_send;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/i2cm_front.sv
`default_nettype none
module i2cm_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 cmd_valid,
  input  wire  [1:0]          mode,
  input  wire  [7:0]          tx_byte,
  input  wire                 ack_to_send,
  input  wire                 sda_in,
  input  i2cm_pkg::q_status_t q_stat,
  output logic                q_push,
  output i2cm_pkg::tick_t     q_push_data
);
  import i2cm_pkg::*;

  logic  hold_valid;
  logic  hold_valid_next;
  tick_t hold;
  tick_t decoded;
  logic  accept;

  // A tick without a command is still forwarded; the engine counts it.
  always_comb begin
    decoded.tx_byte     = tx_byte;
    decoded.ack_to_send = ack_to_send;
    decoded.sda_in      = sda_in;
    decoded.kind        = KIND_NONE;
    if (cmd_valid) begin
      unique case (mode)
        MODE_START: decoded.kind = KIND_START;
        MODE_STOP:  decoded.kind = KIND_STOP;
        MODE_WRITE: decoded.kind = KIND_WRITE;
        MODE_READ:  decoded.kind = KIND_READ;
        default:    decoded.kind = KIND_NONE;
      endcase
    end
  end

  assign q_push      = hold_valid && !q_stat.full;
  assign q_push_data = hold;
  assign in_stall    = hold_valid && q_stat.full;
  assign accept      = in_valid && !in_stall;

  always_comb begin
    hold_valid_next = hold_valid;
    if (accept) begin
      hold_valid_next = 1'b1;
    end else if (q_push) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= decoded;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/i2cm_queue.sv
`default_nettype none
module i2cm_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  i2cm_pkg::tick_t     push_data,
  input  wire                 pop,
  output i2cm_pkg::tick_t     pop_data,
  output i2cm_pkg::q_status_t q_stat
);
  import i2cm_pkg::*;

  tick_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign q_stat.full  = (count == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_data     = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/i2cm_back.sv
`default_nettype none
module i2cm_back (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_we,
  input  wire  [i2cm_pkg::DELAY_W-1:0] cfg_data,
  input  i2cm_pkg::q_status_t         q_stat,
  input  i2cm_pkg::tick_t             item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        scl_out,
  output logic                        sda_out,
  output logic                        busy_res,
  output logic                        done_res,
  output logic [7:0]                  rx_byte,
  output logic                        ack_seen
);
  import i2cm_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_START_A  = 4'd1;
  localparam logic [3:0] PH_START_B  = 4'd2;
  localparam logic [3:0] PH_STOP_A   = 4'd3;
  localparam logic [3:0] PH_STOP_B   = 4'd4;
  localparam logic [3:0] PH_W_LOW    = 4'd5;
  localparam logic [3:0] PH_W_DATA   = 4'd6;
  localparam logic [3:0] PH_W_HIGH   = 4'd7;
  localparam logic [3:0] PH_ACK_LOW  = 4'd8;
  localparam logic [3:0] PH_ACK_HIGH = 4'd9;
  localparam logic [3:0] PH_ACK_TAIL = 4'd10;
  localparam logic [3:0] PH_R_HIGH   = 4'd11;
  localparam logic [3:0] PH_R_LOW    = 4'd12;
  localparam logic [3:0] PH_SA_A     = 4'd13;
  localparam logic [3:0] PH_SA_B     = 4'd14;
  localparam logic [3:0] PH_SA_C     = 4'd15;

  logic [DELAY_W-1:0] delay_ticks;
  logic [DELAY_W-1:0] step_len;
  logic [3:0]         phase,       phase_next;
  logic [DELAY_W-1:0] delay_count, delay_count_next;
  logic [3:0]         bit_count,   bit_count_next;
  logic [3:0]         bit_inc;
  logic [7:0]         shift_reg,   shift_reg_next;
  logic [7:0]         rx_hold,     rx_hold_next;
  logic               ack_bit,     ack_bit_next;
  logic               ack_pending, ack_pending_next;
  logic               scl_level,   scl_level_next;
  logic               sda_level,   sda_level_next;
  logic               done,        done_next;
  logic               out_valid_next;

  // The engine state doubles as the output register: it only advances
  // when the previous result has been taken or the slot is empty.
  assign q_pop    = !q_stat.empty && (!out_valid || !out_stall);
  assign step_len = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
  assign bit_inc  = bit_count + 4'd1;

  assign scl_out  = scl_level;
  assign sda_out  = sda_level;
  assign busy_res = (phase != PH_IDLE);
  assign done_res = done;
  assign rx_byte  = rx_hold;
  assign ack_seen = ack_bit;

  always_comb begin
    phase_next       = phase;
    delay_count_next = delay_count;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    rx_hold_next     = rx_hold;
    ack_bit_next     = ack_bit;
    ack_pending_next = ack_pending;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    done_next        = done;
    out_valid_next   = out_valid && out_stall;

    if (q_pop) begin
      out_valid_next = 1'b1;
      done_next      = 1'b0;
      if (phase == PH_IDLE) begin
        unique case (item.kind)
          KIND_START: begin
            bit_count_next   = '0;
            sda_level_next   = 1'b1;
            scl_level_next   = 1'b1;
            phase_next       = PH_START_A;
            delay_count_next = step_len;
          end
          KIND_STOP: begin
            bit_count_next   = '0;
            sda_level_next   = 1'b0;
            scl_level_next   = 1'b1;
            phase_next       = PH_STOP_A;
            delay_count_next = step_len;
          end
          KIND_WRITE: begin
            bit_count_next   = '0;
            shift_reg_next   = item.tx_byte;
            scl_level_next   = 1'b0;
            phase_next       = PH_W_LOW;
            delay_count_next = step_len;
          end
          KIND_READ: begin
            bit_count_next   = '0;
            ack_pending_next = item.ack_to_send;
            shift_reg_next   = '0;
            sda_level_next   = 1'b1;
            scl_level_next   = 1'b1;
            phase_next       = PH_R_HIGH;
            delay_count_next = step_len;
          end
          default: begin
          end
        endcase
      end else if (delay_count > DELAY_W'(1)) begin
        delay_count_next = delay_count - DELAY_W'(1);
      end else begin
        unique case (phase)
          PH_START_A: begin
            sda_level_next   = 1'b0;
            phase_next       = PH_START_B;
            delay_count_next = step_len;
          end
          PH_START_B: begin
            scl_level_next = 1'b0;
            phase_next     = PH_IDLE;
            done_next      = 1'b1;
          end
          PH_STOP_A: begin
            sda_level_next   = 1'b1;
            phase_next       = PH_STOP_B;
            delay_count_next = step_len;
          end
          PH_STOP_B: begin
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end
          PH_W_LOW: begin
            sda_level_next   = shift_reg[7];
            phase_next       = PH_W_DATA;
            delay_count_next = step_len;
          end
          PH_W_DATA: begin
            scl_level_next   = 1'b1;
            shift_reg_next   = {shift_reg[6:0], 1'b0};
            phase_next       = PH_W_HIGH;
            delay_count_next = step_len;
          end
          PH_W_HIGH: begin
            bit_count_next = bit_inc;
            scl_level_next = 1'b0;
            if (bit_inc < 4'd8) begin
              phase_next       = PH_W_LOW;
              delay_count_next = step_len;
            end else begin
              // SDA is released for the acknowledge; the low phase is one tick.
              sda_level_next   = 1'b1;
              phase_next       = PH_ACK_LOW;
              delay_count_next = DELAY_W'(1);
            end
          end
          PH_ACK_LOW: begin
            scl_level_next   = 1'b1;
            phase_next       = PH_ACK_HIGH;
            delay_count_next = step_len;
          end
          PH_ACK_HIGH: begin
            ack_bit_next     = item.sda_in;
            scl_level_next   = 1'b0;
            phase_next       = PH_ACK_TAIL;
            delay_count_next = step_len;
          end
          PH_R_HIGH: begin
            shift_reg_next   = {shift_reg[6:0], item.sda_in};
            scl_level_next   = 1'b0;
            phase_next       = PH_R_LOW;
            delay_count_next = step_len;
          end
          PH_R_LOW: begin
            bit_count_next   = bit_inc;
            delay_count_next = step_len;
            if (bit_inc < 4'd8) begin
              scl_level_next = 1'b1;
              phase_next     = PH_R_HIGH;
            end else begin
              rx_hold_next   = shift_reg;
              scl_level_next = 1'b0;
              sda_level_next = ack_pending;
              phase_next     = PH_SA_A;
            end
          end
          PH_SA_A: begin
            scl_level_next   = 1'b1;
            phase_next       = PH_SA_B;
            delay_count_next = step_len;
          end
          PH_SA_B: begin
            scl_level_next   = 1'b0;
            sda_level_next   = 1'b1;
            phase_next       = PH_SA_C;
            delay_count_next = step_len;
          end
          default: begin
            // Acknowledge tail of a write and the last step of a read.
            phase_next = PH_IDLE;
            done_next  = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= DELAY_RESET;
      phase       <= PH_IDLE;
      delay_count <= '0;
      bit_count   <= '0;
      shift_reg   <= '0;
      rx_hold     <= '0;
      ack_bit     <= 1'b1;
      ack_pending <= 1'b1;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      done        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        delay_ticks <= cfg_data;
      end
      phase       <= phase_next;
      delay_count <= delay_count_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      rx_hold     <= rx_hold_next;
      ack_bit     <= ack_bit_next;
      ack_pending <= ack_pending_next;
      scl_level   <= scl_level_next;
      sda_level   <= sda_level_next;
      done        <= done_next;
      out_valid   <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/i2c_master_bit_engine.sv
// A request is held in the input stage register, then written into the queue, then
// taken by the engine state registers. Throughput: one request per cycle unless out_stall holds the engine.
// A four-entry queue between input stage and engine absorbs output stalls.
// Reset (synchronous, active high): engine idle, SCL and SDA released, delay of 90 ticks,
// received byte zero, acknowledge seen one, queue and output empty.
`default_nettype none
`include "i2c_master_bit_engine_assert.svh"
module i2c_master_bit_engine (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [i2cm_pkg::DELAY_W-1:0] cfg_data,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire                         cmd_valid,
  input  wire  [1:0]                  mode,
  input  wire  [7:0]                  tx_byte,
  input  wire                         ack_to_send,
  input  wire                         sda_in,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        scl_out,
  output logic                        sda_out,
  output logic                        busy_res,
  output logic                        done_res,
  output logic [7:0]                  rx_byte,
  output logic                        ack_seen
);
  import i2cm_pkg::*;

  q_status_t q_stat;
  tick_t     q_push_data;
  tick_t     q_pop_data;
  logic      q_push;
  logic      q_pop;

  assign cfg_ready = 1'b1;

  i2cm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd_valid   (cmd_valid),
    .mode        (mode),
    .tx_byte     (tx_byte),
    .ack_to_send (ack_to_send),
    .sda_in      (sda_in),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .q_stat    (q_stat)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .item      (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .scl_out   (scl_out),
    .sda_out   (sda_out),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .rx_byte   (rx_byte),
    .ack_seen  (ack_seen)
  );

  `I2CM_ASSERT_NEVER(a_no_push_when_full, clk, rst, q_push && q_stat.full)
  `I2CM_ASSERT_NEVER(a_no_pop_when_empty, clk, rst, q_pop && q_stat.empty)
  `I2CM_ASSERT_IMPLIES(a_pop_needs_free_slot, clk, rst, q_pop, !out_valid || !out_stall)
  `I2CM_ASSERT_NEVER(a_done_means_idle, clk, rst, out_valid && done_res && busy_res)

endmodule
`default_nettype wire
